### rtl/core/sha_pkg.sv
// Shared types, constants and round functions for the SHA-256 hash block.
// Used by sha_ctrl, sha_sched, sha_round and the top level sha256_hash.
package sha_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       is_last;
	} sha_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} sha_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMP,
		ST_FOLD,
		ST_OUT
	} sha_state_t;

	// Commands from the sequencer to the schedule and round datapaths.
	typedef struct packed {
		logic       wr_en;
		logic [5:0] wr_pos;
		logic [7:0] wr_byte;
		logic       load;
		logic       rnd_en;
		logic [5:0] rnd;
		logic       fold;
		logic       hinit;
		logic [2:0] out_idx;
	} sha_ctrl_t;

	localparam logic [7:0] PAD_MARK  = 8'h80;
	localparam logic [7:0] PAD_ZERO  = 8'h00;
	localparam logic [5:0] LAST_POS  = 6'd63;
	localparam logic [5:0] LEN_START = 6'd55;
	localparam logic [5:0] LAST_RND  = 6'd63;
	localparam logic [2:0] LAST_WORD = 3'd7;
	localparam logic [63:0] BYTE_BITS = 64'd8;

	function automatic logic [31:0] init_hash(input logic [2:0] idx);
		logic [31:0] v;
		case (idx)
			3'd0: v = 32'h6a09e667;
			3'd1: v = 32'hbb67ae85;
			3'd2: v = 32'h3c6ef372;
			3'd3: v = 32'ha54ff53a;
			3'd4: v = 32'h510e527f;
			3'd5: v = 32'h9b05688c;
			3'd6: v = 32'h1f83d9ab;
			default: v = 32'h5be0cd19;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] idx);
		logic [31:0] v;
		case (idx)
			6'd0:  v = 32'h428a2f98;
			6'd1:  v = 32'h71374491;
			6'd2:  v = 32'hb5c0fbcf;
			6'd3:  v = 32'he9b5dba5;
			6'd4:  v = 32'h3956c25b;
			6'd5:  v = 32'h59f111f1;
			6'd6:  v = 32'h923f82a4;
			6'd7:  v = 32'hab1c5ed5;
			6'd8:  v = 32'hd807aa98;
			6'd9:  v = 32'h12835b01;
			6'd10: v = 32'h243185be;
			6'd11: v = 32'h550c7dc3;
			6'd12: v = 32'h72be5d74;
			6'd13: v = 32'h80deb1fe;
			6'd14: v = 32'h9bdc06a7;
			6'd15: v = 32'hc19bf174;
			6'd16: v = 32'he49b69c1;
			6'd17: v = 32'hefbe4786;
			6'd18: v = 32'h0fc19dc6;
			6'd19: v = 32'h240ca1cc;
			6'd20: v = 32'h2de92c6f;
			6'd21: v = 32'h4a7484aa;
			6'd22: v = 32'h5cb0a9dc;
			6'd23: v = 32'h76f988da;
			6'd24: v = 32'h983e5152;
			6'd25: v = 32'ha831c66d;
			6'd26: v = 32'hb00327c8;
			6'd27: v = 32'hbf597fc7;
			6'd28: v = 32'hc6e00bf3;
			6'd29: v = 32'hd5a79147;
			6'd30: v = 32'h06ca6351;
			6'd31: v = 32'h14292967;
			6'd32: v = 32'h27b70a85;
			6'd33: v = 32'h2e1b2138;
			6'd34: v = 32'h4d2c6dfc;
			6'd35: v = 32'h53380d13;
			6'd36: v = 32'h650a7354;
			6'd37: v = 32'h766a0abb;
			6'd38: v = 32'h81c2c92e;
			6'd39: v = 32'h92722c85;
			6'd40: v = 32'ha2bfe8a1;
			6'd41: v = 32'ha81a664b;
			6'd42: v = 32'hc24b8b70;
			6'd43: v = 32'hc76c51a3;
			6'd44: v = 32'hd192e819;
			6'd45: v = 32'hd6990624;
			6'd46: v = 32'hf40e3585;
			6'd47: v = 32'h106aa070;
			6'd48: v = 32'h19a4c116;
			6'd49: v = 32'h1e376c08;
			6'd50: v = 32'h2748774c;
			6'd51: v = 32'h34b0bcb5;
			6'd52: v = 32'h391c0cb3;
			6'd53: v = 32'h4ed8aa4a;
			6'd54: v = 32'h5b9cca4f;
			6'd55: v = 32'h682e6ff3;
			6'd56: v = 32'h748f82ee;
			6'd57: v = 32'h78a5636f;
			6'd58: v = 32'h84c87814;
			6'd59: v = 32'h8cc70208;
			6'd60: v = 32'h90befffa;
			6'd61: v = 32'ha4506ceb;
			6'd62: v = 32'hbef9a3f7;
			default: v = 32'hc67178f2;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

### rtl/core/sha_ctrl.sv
// Sequencer of the SHA-256 block: byte position, padding, round count and
// digest readout. Depends on sha_pkg.
module sha_ctrl import sha_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  sha_in_t   in_word,
	output logic      out_valid,
	input  logic      out_ready,
	output sha_ctrl_t ctrl
);

	sha_state_t  state_q, state_d;
	logic [5:0]  pos_q, pos_d;
	logic [5:0]  rnd_q, rnd_d;
	logic        mark_q, mark_d;
	logic        len_ok_q, len_ok_d;
	logic        fin_q, fin_d;
	logic [63:0] bits_q, bits_d;
	logic [2:0]  oidx_q, oidx_d;
	logic [7:0]  pad_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pos_q    <= '0;
			rnd_q    <= '0;
			mark_q   <= 1'b0;
			len_ok_q <= 1'b0;
			fin_q    <= 1'b0;
			bits_q   <= '0;
			oidx_q   <= '0;
		end else begin
			state_q  <= state_d;
			pos_q    <= pos_d;
			rnd_q    <= rnd_d;
			mark_q   <= mark_d;
			len_ok_q <= len_ok_d;
			fin_q    <= fin_d;
			bits_q   <= bits_d;
			oidx_q   <= oidx_d;
		end
	end

	// Padding byte: the mark first, then zeros, then the bit length big-endian
	// once a pad byte has landed just before the length field of a block.
	always_comb begin
		if (!mark_q) begin
			pad_byte = PAD_MARK;
		end else if (len_ok_q) begin
			pad_byte = bits_q[{~pos_q[2:0], 3'b000} +: 8];
		end else begin
			pad_byte = PAD_ZERO;
		end
	end

	always_comb begin
		state_d   = state_q;
		pos_d     = pos_q;
		rnd_d     = rnd_q;
		mark_d    = mark_q;
		len_ok_d  = len_ok_q;
		fin_d     = fin_q;
		bits_d    = bits_q;
		oidx_d    = oidx_q;
		ctrl         = '0;
		ctrl.wr_pos  = pos_q;
		ctrl.rnd     = rnd_q;
		ctrl.out_idx = oidx_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_word.has_byte) begin
						ctrl.wr_en   = 1'b1;
						ctrl.wr_byte = in_word.data_byte;
						bits_d       = bits_q + BYTE_BITS;
					end
					if (in_word.is_last) begin
						fin_d = 1'b1;
					end
					if (in_word.has_byte && pos_q == LAST_POS) begin
						ctrl.load = 1'b1;
						state_d   = ST_COMP;
					end else if (in_word.is_last) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				ctrl.wr_en   = 1'b1;
				ctrl.wr_byte = pad_byte;
				mark_d       = 1'b1;
				if (pos_q == LEN_START) begin
					len_ok_d = 1'b1;
				end
				if (pos_q == LAST_POS) begin
					ctrl.load = 1'b1;
					state_d   = ST_COMP;
				end
			end
			ST_COMP: begin
				ctrl.rnd_en = 1'b1;
				rnd_d       = rnd_q + 6'd1;
				if (rnd_q == LAST_RND) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				ctrl.fold = 1'b1;
				if (!fin_q) begin
					state_d = ST_IDLE;
				end else if (len_ok_q) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_PAD;
				end
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					oidx_d = oidx_q + 3'd1;
					if (oidx_q == LAST_WORD) begin
						ctrl.hinit = 1'b1;
						mark_d     = 1'b0;
						len_ok_d   = 1'b0;
						fin_d      = 1'b0;
						bits_d     = '0;
						state_d    = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (ctrl.wr_en) begin
			pos_d = pos_q + 6'd1;
		end
	end

	// A block is only compressed once all 64 of its bytes are in place.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMP) |-> (pos_q == '0))
		else $error("byte position not at block start during compression");

	assert property (@(posedge clk) disable iff (!arst_n)
		len_ok_q |-> (mark_q && fin_q))
		else $error("length field armed without padding mark");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FOLD) |-> ($past(rnd_q) == LAST_RND && rnd_q == '0))
		else $error("fold entered before all rounds ran");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_OUT) |-> (oidx_q == '0))
		else $error("digest word index not cleared outside readout");

endmodule

### rtl/core/sha_sched.sv
// Message schedule window: packs bytes into sixteen 32-bit words and then
// rolls out one schedule word per round. Depends on sha_pkg.
module sha_sched import sha_pkg::*; (
	input  logic        clk,
	input  sha_ctrl_t   ctrl,
	output logic [31:0] w_cur
);

	logic [31:0] win_q [16];
	logic [31:0] w_next;

	// W[t+16] from the window that currently holds W[t] .. W[t+15].
	assign w_next = ssig1(win_q[14]) + win_q[9] + ssig0(win_q[1]) + win_q[0];
	assign w_cur  = win_q[0];

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			win_q[ctrl.wr_pos[5:2]][{~ctrl.wr_pos[1:0], 3'b000} +: 8] <= ctrl.wr_byte;
		end else if (ctrl.rnd_en) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= w_next;
		end
	end

endmodule

### rtl/core/sha_round.sv
// Compression datapath: working variables a..h, one round per cycle, and the
// hash words with their fold-in adders. Depends on sha_pkg.
module sha_round import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  sha_ctrl_t   ctrl,
	input  logic [31:0] w_cur,
	output logic [31:0] hash_word
);

	logic [31:0] v_q [8];
	logic [31:0] h_q [8];
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] ch;
	logic [31:0] mj;

	always_comb begin
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1 = v_q[7] + bsig1(v_q[4]) + ch + round_k(ctrl.rnd) + w_cur;
		t2 = bsig0(v_q[0]) + mj;
	end

	assign hash_word = h_q[ctrl.out_idx];

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (ctrl.rnd_en) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= init_hash(3'(i));
			end
		end else if (ctrl.hinit) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= init_hash(3'(i));
			end
		end else if (ctrl.fold) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= h_q[i] + v_q[i];
			end
		end
	end

endmodule

### rtl/core/sha256_hash.sv
// Channel | dir | payload   | fields
// in      | in  | sha_in_t  | data_byte, has_byte, is_last
// out     | out | sha_out_t | digest_word, word_index, last_word
//
// A word that does not close a block only writes its byte; the word that fills a
// block starts a compression on the single shared round unit, followed by a
// fold. A last word adds padding and one or two block compressions, then eight
// digest words, each held until out_ready is high.
// in_ready is high only while the sequencer is idle; reset returns the hash to
// its initial values with an empty message. Top level; depends on sha_pkg.
module sha256_hash import sha_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  sha_in_t  in_word,
	output logic     out_valid,
	input  logic     out_ready,
	output sha_out_t out_word
);

	sha_ctrl_t   ctrl;
	logic [31:0] w_cur;
	logic [31:0] hash_word;

	sha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctrl      (ctrl)
	);

	sha_sched u_sched (
		.clk   (clk),
		.ctrl  (ctrl),
		.w_cur (w_cur)
	);

	sha_round u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.w_cur     (w_cur),
		.hash_word (hash_word)
	);

	always_comb begin
		out_word.digest_word = hash_word;
		out_word.word_index  = ctrl.out_idx;
		out_word.last_word   = (ctrl.out_idx == LAST_WORD);
	end

endmodule

### dv/sha256_digest_check.sv
// Digest checker for the SHA-256 hash block: watches both channels, keeps its own
// SHA-256 state, and compares every output word against the predicted digest.
// Depends on sha_pkg for the channel word types.
module sha256_digest_check import sha_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_ready,
	input  sha_in_t  in_word,
	input  logic     out_valid,
	input  logic     out_ready,
	input  sha_out_t out_word,
	output int       fail_count,
	output int       pending,
	output int       words_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [0:7][31:0] IV = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [0:63][31:0] KS = {
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	logic [31:0] hash_st [8];
	logic [31:0] msg_blk [16];
	logic [5:0]  blk_fill;
	logic [63:0] msg_bits;
	sha_out_t    digest_q [$];
	int          n_fail;
	int          n_checked;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2;
		int r;
		for (r = 0; r < 16; r++)
			w[r] = msg_blk[r];
		for (r = 16; r < 64; r++) begin
			w[r] = w[r-16] + w[r-7]
				+ (rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3))
				+ (rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10));
		end
		for (r = 0; r < 8; r++)
			v[r] = hash_st[r];
		for (r = 0; r < 64; r++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + KS[r] + w[r];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (r = 0; r < 8; r++)
			hash_st[r] = hash_st[r] + v[r];
	endtask

	// Bytes pack big-endian into the block; the 64th byte triggers compression.
	task automatic absorb_byte(input logic [7:0] b);
		int sh;
		sh = 24 - 8 * blk_fill[1:0];
		msg_blk[blk_fill[5:2]][sh +: 8] = b;
		blk_fill = blk_fill + 6'd1;
		if (blk_fill == 6'd0)
			compress_block();
	endtask

	task automatic close_message();
		logic [63:0] len;
		int i;
		len = msg_bits;
		absorb_byte(8'h80);
		while (blk_fill != 6'd56)
			absorb_byte(8'h00);
		for (i = 0; i < 8; i++)
			absorb_byte(len[63 - 8*i -: 8]);
		for (i = 0; i < 8; i++)
			digest_q.push_back(sha_out_t'{hash_st[i], 3'(i), i == 7});
		for (i = 0; i < 8; i++)
			hash_st[i] = IV[i];
		msg_bits = '0;
	endtask

	task automatic compare_word(input sha_out_t got);
		sha_out_t exp_w;
		if (digest_q.size() == 0) begin
			$error("digest word %h at index %0d with no digest pending",
				got.digest_word, got.word_index);
			n_fail++;
		end else begin
			exp_w = digest_q.pop_front();
			n_checked++;
			if (got.digest_word !== exp_w.digest_word) begin
				$error("digest_word: expected %h, got %h", exp_w.digest_word, got.digest_word);
				n_fail++;
			end
			if (got.word_index !== exp_w.word_index) begin
				$error("word_index: expected %0d, got %0d", exp_w.word_index, got.word_index);
				n_fail++;
			end
			if (got.last_word !== exp_w.last_word) begin
				$error("last_word: expected %b, got %b", exp_w.last_word, got.last_word);
				n_fail++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				hash_st[i] = IV[i];
			for (int i = 0; i < 16; i++)
				msg_blk[i] = '0;
			blk_fill = '0;
			msg_bits = '0;
			digest_q.delete();
			n_fail = 0;
			n_checked = 0;
			fail_count <= 0;
			pending <= 0;
			words_checked <= 0;
		end else begin
			if (in_valid && in_ready) begin
				if (in_word.has_byte) begin
					absorb_byte(in_word.data_byte);
					msg_bits = msg_bits + 64'd8;
				end
				if (in_word.is_last)
					close_message();
			end
			if (out_valid && out_ready)
				compare_word(out_word);
			fail_count <= n_fail;
			pending <= digest_q.size();
			words_checked <= n_checked;
		end
	end

endmodule

### dv/tb_sha256_hash.sv
// Top of the SHA-256 hash block testbench: clock, reset, byte stimulus and verdict.
// Depends on sha_pkg, sha256_hash and sha256_digest_check.
module tb_sha256_hash;
	import sha_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	sha_in_t  in_word;
	logic     out_valid;
	logic     out_ready;
	sha_out_t out_word;

	int fail_count;
	int pending;
	int words_checked;

	int gap_pct = 14;
	bit hold_req = 1'b0;
	int words_sent = 0;
	int msgs_sent = 0;

	sha256_hash u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	sha256_digest_check u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_word       (in_word),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_word      (out_word),
		.fail_count    (fail_count),
		.pending       (pending),
		.words_checked (words_checked)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Receiver: random back-pressure, plus one long hold-off on request.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready = 1'b0;
				repeat (1000) @(negedge clk);
			end
			out_ready = ($urandom_range(99) >= gap_pct);
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_word(input logic [7:0] b, input logic has, input logic fin);
		while ($urandom_range(99) < gap_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_word = sha_in_t'{b, has, fin};
		do @(posedge clk); while (!in_ready);
		words_sent++;
		@(negedge clk);
	endtask

	// A message of len bytes; the final byte rides on the last word half the time,
	// and idle words with random content are sprinkled in.
	task automatic send_message(input int len);
		int tail;
		int i;
		tail = (len > 0) ? int'($urandom_range(1)) : 0;
		for (i = 0; i < len - tail; i++) begin
			if ($urandom_range(99) < 6)
				send_word(8'($urandom), 1'b0, 1'b0);
			send_word(8'($urandom), 1'b1, 1'b0);
		end
		send_word(8'($urandom), tail[0], 1'b1);
		msgs_sent++;
	endtask

	initial begin
		int pick;
		int rand_msgs;
		int len;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		rand_msgs = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Empty message, with every ignored data bit set.
		send_word(8'hff, 1'b0, 1'b1);
		msgs_sent++;
		// Zero byte, an idle word, then a final 0xff byte on the last word.
		send_word(8'h00, 1'b1, 1'b0);
		send_word(8'h5a, 1'b0, 1'b0);
		send_word(8'hff, 1'b1, 1'b1);
		msgs_sent++;
		send_word(8'h61, 1'b1, 1'b0);
		send_word(8'h62, 1'b1, 1'b0);
		send_word(8'h63, 1'b1, 1'b1);
		msgs_sent++;
		// One-byte message carried entirely by the last word.
		send_word(8'h80, 1'b1, 1'b1);
		msgs_sent++;
		// Idle word first, then a byte, then a byteless last word.
		send_word(8'ha5, 1'b0, 1'b0);
		send_word(8'h00, 1'b1, 1'b0);
		send_word(8'h00, 1'b0, 1'b1);
		msgs_sent++;
		send_word(8'h00, 1'b0, 1'b1);
		msgs_sent++;

		// Lengths are short or cluster around the padding boundaries of one and two blocks.
		gap_pct = 0;
		while (words_sent < 270 || rand_msgs < 8) begin
			if (rand_msgs == 2)
				gap_pct = 14;
			if (rand_msgs == 4)
				hold_req = 1'b1;
			pick = $urandom_range(99);
			if (pick < 50)
				len = int'($urandom_range(12));
			else if (pick < 80)
				len = int'($urandom_range(70, 52));
			else
				len = int'($urandom_range(130, 115));
			// Keep the total near the word budget; late messages shrink toward empty.
			if (len > 270 - words_sent)
				len = (words_sent < 270) ? 270 - words_sent : 0;
			send_message(len);
			rand_msgs++;
		end
		in_valid = 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
		$display("Sent %0d input words in %0d messages; compared %0d digest words.",
			words_sent, msgs_sent, words_checked);
		$display("Covered empty and byteless-last messages, idle words, block-boundary "
			, "padding and a long output stall.");
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### filelist.f
rtl/core/sha_pkg.sv
rtl/core/sha_ctrl.sv
rtl/core/sha_sched.sv
rtl/core/sha_round.sv
rtl/core/sha256_hash.sv
dv/sha256_digest_check.sv
dv/tb_sha256_hash.sv
